[rtl/fwdgr_pkg.sv]
// ----------------------------------------------------------------------------
// fwdgr_pkg
// shared constants, types and the 6x8 digit font for the glyph renderer
// ----------------------------------------------------------------------------
package fwdgr_pkg;

    localparam int VALUE_W       = 32;
    localparam int DEC_DIGITS    = 10;
    localparam int BCD_W         = 4 * DEC_DIGITS;
    localparam int COUNT_W       = 4;
    localparam int COL_W         = 8;
    localparam int GLYPH_COLUMNS = 6;
    localparam int MAX_DIGITS    = 10;
    localparam int COLIDX_W      = $clog2(GLYPH_COLUMNS);
    localparam int SHIFT_CNT_W   = $clog2(VALUE_W + 1);

    localparam logic [3:0] DIGIT_NINE = 4'd9;

    // conversion result handed from the converter to the column emitter
    typedef struct packed {
        logic             done;
        logic [BCD_W-1:0] bcd;
    } t_conv_res;

    // font column lookup, bit 0 is the top row
    function automatic logic [COL_W-1:0] f_glyph_column(input logic [3:0] digit,
                                                        input logic [COLIDX_W-1:0] col);
        logic [8*GLYPH_COLUMNS-1:0] glyph;
        begin
            case (digit)
                4'd0:    glyph = 48'h3C_52_4A_46_3C_00;
                4'd1:    glyph = 48'h00_44_7E_40_00_00;
                4'd2:    glyph = 48'h44_62_52_4A_44_00;
                4'd3:    glyph = 48'h24_42_4A_4A_34_00;
                4'd4:    glyph = 48'h30_28_24_7E_20_00;
                4'd5:    glyph = 48'h2E_4A_4A_4A_32_00;
                4'd6:    glyph = 48'h3C_4A_4A_4A_32_00;
                4'd7:    glyph = 48'h02_02_72_0A_06_00;
                4'd8:    glyph = 48'h34_4A_4A_4A_34_00;
                4'd9:    glyph = 48'h24_4A_4A_4A_3C_00;
                default: glyph = '0;
            endcase
            f_glyph_column = glyph[8*(GLYPH_COLUMNS-1-int'(col)) +: 8];
        end
    endfunction

endpackage

[rtl/fwdgr_bcd_conv.sv]
// ----------------------------------------------------------------------------
// fwdgr_bcd_conv
// bit-serial binary to bcd converter, one input bit shifted in per cycle
// ----------------------------------------------------------------------------
module fwdgr_bcd_conv (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_load,
    input  logic [fwdgr_pkg::VALUE_W-1:0]     i_value,
    output fwdgr_pkg::t_conv_res              o_res
);
    import fwdgr_pkg::*;

    logic                   r_busy, n_busy;
    logic                   r_done, n_done;
    logic [SHIFT_CNT_W-1:0] r_cnt, n_cnt;
    logic [VALUE_W-1:0]     r_shift, n_shift;
    logic [BCD_W-1:0]       r_bcd, n_bcd;
    logic [BCD_W-1:0]       adj;

    // add three to every digit of five or more before the shift
    always_comb begin
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_shift = r_shift;
        n_bcd   = r_bcd;
        if (i_load) begin
            n_busy  = 1'b1;
            n_cnt   = SHIFT_CNT_W'(VALUE_W);
            n_shift = i_value;
            n_bcd   = '0;
        end else if (r_busy) begin
            n_shift = {r_shift[VALUE_W-2:0], 1'b0};
            n_bcd   = {adj[BCD_W-2:0], r_shift[VALUE_W-1]};
            n_cnt   = r_cnt - 1'b1;
            if (r_cnt == SHIFT_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_shift <= n_shift;
        r_bcd   <= n_bcd;
    end

    assign o_res.done = r_done;
    assign o_res.bcd  = r_bcd;

endmodule

[rtl/fwdgr_emit.sv]
// ----------------------------------------------------------------------------
// fwdgr_emit
// walks the bcd digits most significant first and sends one font column per cycle
// ----------------------------------------------------------------------------
module fwdgr_emit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  fwdgr_pkg::t_conv_res              i_res,
    input  logic [fwdgr_pkg::COUNT_W-1:0]     i_count,
    input  logic                              i_invert,
    output logic                              o_valid,
    output logic [fwdgr_pkg::COL_W-1:0]       o_column,
    output logic                              o_last
);
    import fwdgr_pkg::*;

    logic                r_run, n_run;
    logic                r_first, n_first;
    logic [COUNT_W-1:0]  r_dig, n_dig;
    logic [COLIDX_W-1:0] r_col, n_col;
    logic [BCD_W-1:0]    r_bcd;
    logic                r_ovf;
    logic                ovf;
    logic                r_valid;
    logic [COL_W-1:0]    r_column;
    logic                r_last;
    logic [3:0]          digit;
    logic [COL_W-1:0]    col_byte;
    logic                is_last;

    // any nonzero digit above the shown width forces the leading glyph to nine
    always_comb begin
        ovf = 1'b0;
        for (int i = 0; i < DEC_DIGITS; i++) begin
            if (COUNT_W'(i) >= i_count && i_res.bcd[4*i +: 4] != 4'd0) begin
                ovf = 1'b1;
            end
        end
    end

    always_comb begin
        digit = r_bcd[{r_dig, 2'b00} +: 4];
        if (r_first && r_ovf) begin
            digit = DIGIT_NINE;
        end
        col_byte = f_glyph_column(digit, r_col);
        if (i_invert) begin
            col_byte = ~col_byte;
        end
        is_last = (r_dig == '0) && (r_col == COLIDX_W'(GLYPH_COLUMNS - 1));
    end

    always_comb begin
        n_run   = r_run;
        n_first = r_first;
        n_dig   = r_dig;
        n_col   = r_col;
        if (i_res.done) begin
            n_run   = 1'b1;
            n_first = 1'b1;
            n_dig   = i_count - 1'b1;
            n_col   = '0;
        end else if (r_run) begin
            if (r_col == COLIDX_W'(GLYPH_COLUMNS - 1)) begin
                n_col   = '0;
                n_dig   = r_dig - 1'b1;
                n_first = 1'b0;
                if (is_last) begin
                    n_run = 1'b0;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_run   <= n_run;
            r_valid <= r_run;
        end
        r_first  <= n_first;
        r_dig    <= n_dig;
        r_col    <= n_col;
        r_column <= col_byte;
        r_last   <= is_last;
        if (i_res.done) begin
            r_bcd <= i_res.bcd;
            r_ovf <= ovf;
        end
    end

    assign o_valid  = r_valid;
    assign o_column = r_column;
    assign o_last   = r_last;

endmodule

[rtl/fixed_width_decimal_glyph_renderer_top.sv]
// ----------------------------------------------------------------------------
// fixed_width_decimal_glyph_renderer_top
// renders a 32-bit value as zero-padded decimal font columns, 6 per digit
// ----------------------------------------------------------------------------
// A number is taken when start is high and busy is low. The value is first
// converted to bcd one bit per cycle, then the digits go out most significant
// first as 6 column words each, one word per cycle on o_valid, with o_last on
// the final word. Busy stays high until the final word is sent, so no new
// number is taken before then. The receiver must take every word in the cycle
// it is shown: there is no back-pressure.
module fixed_width_decimal_glyph_renderer_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [fwdgr_pkg::VALUE_W-1:0]     i_value,
    input  logic [fwdgr_pkg::COUNT_W-1:0]     i_digit_count,
    input  logic                              i_invert,
    output logic                              o_valid,
    output logic [fwdgr_pkg::COL_W-1:0]       o_column,
    output logic                              o_last
);
    import fwdgr_pkg::*;

    logic               r_busy;
    logic [COUNT_W-1:0] r_count;
    logic               r_invert;
    logic [COUNT_W-1:0] count_clamped;
    logic               accept;
    t_conv_res          conv_res;

    assign accept = start && !r_busy;
    assign busy   = r_busy;

    always_comb begin
        count_clamped = i_digit_count;
        if (i_digit_count == '0) begin
            count_clamped = COUNT_W'(1);
        end else if (i_digit_count > COUNT_W'(MAX_DIGITS)) begin
            count_clamped = COUNT_W'(MAX_DIGITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (accept) begin
            r_busy <= 1'b1;
        end else if (o_valid && o_last) begin
            r_busy <= 1'b0;
        end
        if (accept) begin
            r_count  <= count_clamped;
            r_invert <= i_invert;
        end
    end

    fwdgr_bcd_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_value (i_value),
        .o_res   (conv_res)
    );

    fwdgr_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_res    (conv_res),
        .i_count  (r_count),
        .i_invert (r_invert),
        .o_valid  (o_valid),
        .o_column (o_column),
        .o_last   (o_last)
    );

    // words only leave while a number is in flight
    a_valid_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_busy)
        else $error("word sent with no number in flight");

    // the column walk runs without gaps until the final word
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |=> o_valid)
        else $error("gap in column stream");

    // the final word frees the block
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !r_busy)
        else $error("busy held after final word");

    // conversion finishing never coincides with words still leaving
    a_done_idle_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        conv_res.done |-> !o_valid)
        else $error("conversion done while words still leaving");

endmodule
